/* rtl/ppr_pkg.sv */
// shared constants, types and tables of the planar point rotator
package ppr_pkg;

  localparam int ITERATIONS  = 16;
  localparam int COORD_WIDTH = 32;
  localparam int ANGLE_WIDTH = 16;
  localparam int GUARD       = 8;
  localparam int Z_WIDTH     = 32;
  localparam int SHIFT_WIDTH = 5;

  localparam int DP_RAW      = COORD_WIDTH + GUARD + 4;
  localparam int DP_WIDTH    = (DP_RAW > 40) ? DP_RAW : 40;
  localparam int HI_WIDTH    = DP_WIDTH - 32;
  localparam int PH_WIDTH    = HI_WIDTH + 32;
  localparam int Q_WIDTH     = PH_WIDTH + 1 - GUARD;

  localparam logic [63:0] GAIN_K_FULL =
    64'd2608131496 + (64'd1738754331 >> (2 * ITERATIONS));
  localparam logic [31:0] GAIN_K      = GAIN_K_FULL[31:0];
  localparam logic [63:0] ROUND_BIAS  = 64'd1 << (31 + GUARD);

  localparam logic [31:0] ATAN_TABLE [32] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
    32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
  };

  typedef logic signed [DP_WIDTH-1:0] wide_t;

  typedef struct packed {
    wide_t              x;
    wide_t              y;
    logic [Z_WIDTH-1:0] z;
  } cordic_state_t;

endpackage

/* rtl/ppr_in_if.sv */
// input channel of the planar point rotator
interface ppr_in_if import ppr_pkg::*;;
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] x_in;
  logic signed [COORD_WIDTH-1:0] y_in;
  logic signed [ANGLE_WIDTH-1:0] angle;

  modport source (output valid, output x_in, output y_in, output angle, input ready);
  modport sink (input valid, input x_in, input y_in, input angle, output ready);
endinterface

/* rtl/ppr_out_if.sv */
// result channel of the planar point rotator
interface ppr_out_if import ppr_pkg::*;;
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] x_out;
  logic signed [COORD_WIDTH-1:0] y_out;
  logic                          overflow;

  modport source (output valid, output x_out, output y_out, output overflow, input ready);
  modport sink (input valid, input x_out, input y_out, input overflow, output ready);
endinterface

/* rtl/ppr_prerotate.sv */
// input stage: coordinate scaling and half-turn pre-rotation
module ppr_prerotate import ppr_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] x_in,
  input  logic signed [COORD_WIDTH-1:0] y_in,
  input  logic signed [ANGLE_WIDTH-1:0] angle,
  output logic                          out_valid,
  input  logic                          out_ready,
  output cordic_state_t                 out_state
);

  wide_t         x_ext;
  wide_t         y_ext;
  logic          flip;
  cordic_state_t state_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    x_ext = {{(DP_WIDTH-COORD_WIDTH-GUARD){x_in[COORD_WIDTH-1]}}, x_in, {GUARD{1'b0}}};
    y_ext = {{(DP_WIDTH-COORD_WIDTH-GUARD){y_in[COORD_WIDTH-1]}}, y_in, {GUARD{1'b0}}};
    flip  = angle[ANGLE_WIDTH-1] ^ angle[ANGLE_WIDTH-2];
    state_next.x = flip ? -x_ext : x_ext;
    state_next.y = flip ? -y_ext : y_ext;
    state_next.z = {angle[ANGLE_WIDTH-1] ^ flip, angle[ANGLE_WIDTH-2:0],
                    {(Z_WIDTH-ANGLE_WIDTH){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_state <= state_next;
    end
  end

endmodule

/* rtl/ppr_micro_rotate.sv */
// one registered cordic micro-rotation
module ppr_micro_rotate import ppr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [SHIFT_WIDTH-1:0] shift,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  cordic_state_t          in_state,
  output logic                   out_valid,
  input  logic                   out_ready,
  output cordic_state_t          out_state
);

  wide_t              dx;
  wide_t              dy;
  logic [Z_WIDTH-1:0] step_angle;
  cordic_state_t      state_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    dx         = in_state.y >>> shift;
    dy         = in_state.x >>> shift;
    step_angle = ATAN_TABLE[shift];
    if (in_state.z[Z_WIDTH-1]) begin
      state_next.x = in_state.x + dx;
      state_next.y = in_state.y - dy;
      state_next.z = in_state.z + step_angle;
    end else begin
      state_next.x = in_state.x - dx;
      state_next.y = in_state.y + dy;
      state_next.z = in_state.z - step_angle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_state <= state_next;
    end
  end

endmodule

/* rtl/ppr_gain_scale.sv */
// gain compensation, rounding and saturation over three stages
module ppr_gain_scale import ppr_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  cordic_state_t                 in_state,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] x_out,
  output logic signed [COORD_WIDTH-1:0] y_out,
  output logic                          overflow
);

  localparam logic [Q_WIDTH-1:0] LIMIT_POS =
    {{(Q_WIDTH-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [Q_WIDTH-1:0] LIMIT_NEG =
    {{(Q_WIDTH-COORD_WIDTH){1'b0}}, 1'b1, {(COORD_WIDTH-1){1'b0}}};

  // magnitude stage
  logic                v1;
  logic                r1;
  logic [1:0]          neg1;
  logic [DP_WIDTH-1:0] mag_x1;
  logic [DP_WIDTH-1:0] mag_y1;

  // partial product stage
  logic                v2;
  logic                r2;
  logic [1:0]          neg2;
  logic [63:0]         lo_x2;
  logic [63:0]         lo_y2;
  logic [PH_WIDTH-1:0] hi_x2;
  logic [PH_WIDTH-1:0] hi_y2;

  // output stage
  logic                          r3;
  logic signed [COORD_WIDTH-1:0] x_next;
  logic signed [COORD_WIDTH-1:0] y_next;
  logic                          ovf_x;
  logic                          ovf_y;

  function automatic logic [COORD_WIDTH:0] finish(input logic neg,
                                                  input logic [63:0] lo_pp,
                                                  input logic [PH_WIDTH-1:0] hi_pp);
    logic [PH_WIDTH:0]      sum;
    logic [Q_WIDTH-1:0]     q;
    logic [Q_WIDTH-1:0]     limit;
    logic                   ovf;
    logic [COORD_WIDTH-1:0] mag;
    sum   = {1'b0, hi_pp} + (PH_WIDTH+1)'(lo_pp[63:32]);
    q     = sum[PH_WIDTH:GUARD];
    limit = neg ? LIMIT_NEG : LIMIT_POS;
    ovf   = q > limit;
    mag   = ovf ? limit[COORD_WIDTH-1:0] : q[COORD_WIDTH-1:0];
    return {ovf, neg ? -mag : mag};
  endfunction

  assign r3       = !out_valid || out_ready;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign in_ready = r1;

  always_comb begin
    {ovf_x, x_next} = finish(neg2[0], lo_x2, hi_x2);
    {ovf_y, y_next} = finish(neg2[1], lo_y2, hi_y2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (r1) begin
        v1 <= in_valid;
      end
      if (r2) begin
        v2 <= v1;
      end
      if (r3) begin
        out_valid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && in_valid) begin
      neg1   <= {in_state.y[DP_WIDTH-1], in_state.x[DP_WIDTH-1]};
      mag_x1 <= in_state.x[DP_WIDTH-1] ? -in_state.x : in_state.x;
      mag_y1 <= in_state.y[DP_WIDTH-1] ? -in_state.y : in_state.y;
    end
    if (r2 && v1) begin
      neg2  <= neg1;
      lo_x2 <= {32'd0, mag_x1[31:0]} * {32'd0, GAIN_K} + ROUND_BIAS;
      lo_y2 <= {32'd0, mag_y1[31:0]} * {32'd0, GAIN_K} + ROUND_BIAS;
      hi_x2 <= PH_WIDTH'(mag_x1[DP_WIDTH-1:32]) * PH_WIDTH'(GAIN_K);
      hi_y2 <= PH_WIDTH'(mag_y1[DP_WIDTH-1:32]) * PH_WIDTH'(GAIN_K);
    end
    if (r3 && v2) begin
      x_out    <= x_next;
      y_out    <= y_next;
      overflow <= ovf_x | ovf_y;
    end
  end

endmodule

/* rtl/planar_point_rotator.sv */
// planar point rotator top level: cordic rotation of a q16.16 point
//
// point channel: x_in, y_in (signed q16.16) and a signed 16-bit binary
// angle, one turn spanning 65536 units. a transaction moves on a clock
// edge with valid and ready both high.
// result channel: x_out, y_out (signed q16.16, saturated) and overflow,
// set when either coordinate was clamped.
// pipeline: one pre-rotation stage, one stage per micro-rotation and
// three gain compensation stages (magnitude, split partial products,
// sum with rounding and saturation).
// throughput: one point per cycle while result.ready stays high; every
// stage is a register and the pipeline holds up to ITERATIONS + 4 transactions.
// reset clears every valid bit; no result is shown until a point
// has passed the whole pipeline.
// when the receiver stalls, each stage holds its transaction and empty
// stages keep filling, so points are still taken until the pipeline is
// full; nothing is dropped or repeated.
module planar_point_rotator import ppr_pkg::*; (
  input logic     clk,
  input logic     rst,
  ppr_in_if.sink  point,
  ppr_out_if.source result
);

  logic          valid [ITERATIONS+1];
  logic          ready [ITERATIONS+1];
  cordic_state_t state [ITERATIONS+1];

  ppr_prerotate u_prerotate (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (point.valid),
    .in_ready  (point.ready),
    .x_in      (point.x_in),
    .y_in      (point.y_in),
    .angle     (point.angle),
    .out_valid (valid[0]),
    .out_ready (ready[0]),
    .out_state (state[0])
  );

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_stage
    ppr_micro_rotate u_micro_rotate (
      .clk       (clk),
      .rst       (rst),
      .shift     (SHIFT_WIDTH'(i)),
      .in_valid  (valid[i]),
      .in_ready  (ready[i]),
      .in_state  (state[i]),
      .out_valid (valid[i+1]),
      .out_ready (ready[i+1]),
      .out_state (state[i+1])
    );
  end

  ppr_gain_scale u_gain_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (valid[ITERATIONS]),
    .in_ready  (ready[ITERATIONS]),
    .in_state  (state[ITERATIONS]),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .x_out     (result.x_out),
    .y_out     (result.y_out),
    .overflow  (result.overflow)
  );

endmodule
